@@ hw/rtl/oaht_pkg.sv @@
package oaht_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int DEPTH_W     = $clog2(TABLE_DEPTH);

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_SEARCH = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;

  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_QUAD   = 2'd1;
  localparam logic [1:0] MODE_DOUBLE = 2'd2;

  localparam logic [1:0] MARK_FREE = 2'd0;
  localparam logic [1:0] MARK_USED = 2'd1;
  localparam logic [1:0] MARK_GONE = 2'd2;

  localparam logic [2:0] ST_NEW     = 3'd0;
  localparam logic [2:0] ST_UPDATED = 3'd1;
  localparam logic [2:0] ST_FOUND   = 3'd2;
  localparam logic [2:0] ST_MISSING = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  localparam logic [0:0] REG_TABLE_SIZE = 1'd0;
  localparam logic [0:0] REG_PROBE_MODE = 1'd1;

  localparam int KEY_W  = 31;
  localparam int VAL_W  = 32;
  localparam int SIZE_W = 11;

  typedef struct packed {
    logic [1:0]       func;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  slot_index;
    logic [10:0] entries_held;
    logic [31:0] collisions_seen;
  } rsp_t;

  typedef struct packed {
    logic [1:0]       func;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [16:0]      home;
    logic [16:0]      step;
    logic [16:0]      m;
    logic [1:0]       mode;
  } job_t;

endpackage

@@ hw/rtl/oaht_if.sv @@
interface oaht_req_if;
  logic          valid;
  logic          ready;
  oaht_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface oaht_rsp_if;
  logic          valid;
  logic          ready;
  oaht_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface oaht_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [10:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/oaht_front.sv @@
// Accepts requests, computes home = key mod m and the double-hash step
// with a restoring bit-serial divider (one quotient bit per cycle).
module oaht_front (
  input  logic                       clk,
  input  logic                       rst,
  oaht_req_if.sink                   req,
  input  logic [oaht_pkg::SIZE_W-1:0] table_size,
  input  logic [1:0]                 probe_mode,
  output logic                       job_valid,
  input  logic                       job_ready,
  output oaht_pkg::job_t             job
);
  localparam int DEPTH_W = oaht_pkg::DEPTH_W;
  localparam int MW = DEPTH_W + 1;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MOD1 = 2'd1;
  localparam logic [1:0] S_MOD2 = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]  state;
  logic [4:0]  bitn;
  logic [MW:0] rem;
  logic [MW-1:0] m;
  oaht_pkg::req_t hold;
  logic [MW-1:0] home;
  logic [1:0]  mode;
  logic [MW:0] rem_sh;
  logic [MW-1:0] divisor;
  logic [MW-1:0] msz;

  always_comb begin
    if ({{(17-oaht_pkg::SIZE_W){1'b0}}, table_size} < 17'd3) msz = MW'(3);
    else if ({{(17-oaht_pkg::SIZE_W){1'b0}}, table_size} > 17'(1 << DEPTH_W))
      msz = MW'(1 << DEPTH_W);
    else msz = MW'(table_size);
  end

  assign divisor = (state == S_MOD2) ? m - MW'(1) : m;
  assign rem_sh  = {rem[MW-1:0], hold.key[bitn]};
  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      job_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            hold  <= req.payload;
            m     <= msz;
            mode  <= probe_mode;
            rem   <= '0;
            bitn  <= 5'd30;
            state <= S_MOD1;
          end
        end
        S_MOD1, S_MOD2: begin
          if (bitn == 5'd0) begin
            if (state == S_MOD1) begin
              home  <= (rem_sh >= {1'b0, divisor}) ?
                       MW'(rem_sh - {1'b0, divisor}) : MW'(rem_sh);
              rem   <= '0;
              bitn  <= 5'd30;
              state <= S_MOD2;
            end else begin
              job.func  <= hold.func;
              job.key   <= hold.key;
              job.value <= hold.value;
              job.home  <= 17'(home);
              job.step  <= 17'(((rem_sh >= {1'b0, divisor}) ?
                           MW'(rem_sh - {1'b0, divisor}) : MW'(rem_sh)) + MW'(1));
              job.m     <= 17'(m);
              job.mode  <= mode;
              job_valid <= 1'b1;
              state     <= S_DONE;
            end
          end else begin
            if (rem_sh >= {1'b0, divisor}) rem <= rem_sh - {1'b0, divisor};
            else rem <= rem_sh;
            bitn <= bitn - 5'd1;
          end
        end
        S_DONE: begin
          if (job_ready) begin
            job_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_job_only_done: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> state == S_DONE) else $error("job valid outside done");
  a_home_lt_m: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> job.home < job.m) else $error("home out of range");
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> (job.step != 17'd0 && job.step < job.m))
    else $error("step out of range");
endmodule

@@ hw/rtl/oaht_back.sv @@
// Probe walk over the slot memory. Each probe reads its slot in READ and
// compares it in CHECK. After reset a clearing pass marks every slot free.
module oaht_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  output logic           job_ready,
  input  oaht_pkg::job_t job,
  oaht_rsp_if.source     rsp
);
  localparam int DEPTH_W = oaht_pkg::DEPTH_W;
  localparam int DEPTH = 1 << DEPTH_W;
  localparam int MW = DEPTH_W + 1;
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [oaht_pkg::KEY_W-1:0] mem_key [DEPTH];
  logic [oaht_pkg::VAL_W-1:0] mem_val [DEPTH];
  logic [1:0]                 mem_mark [DEPTH];

  logic [2:0]  state;
  logic [MW-1:0] clr;
  oaht_pkg::job_t cur;
  logic [DEPTH_W-1:0] h, start;
  logic [MW-1:0] k;
  logic [MW-1:0] off;      // f(k) mod m, kept incrementally
  logic [MW-1:0] sq_inc;   // 2k-1 mod m for quadratic
  logic [oaht_pkg::KEY_W-1:0] rd_key;
  logic [1:0]  rd_mark;
  logic [10:0] entries;
  logic [31:0] colls;
  logic [MW-1:0] m, home, step;
  logic [MW-1:0] delta, off_next, inc_next, h_next;
  logic [MW:0]   t1, t2, t3;
  logic is_ins, is_find;
  logic walk_end;

  assign m    = cur.m[MW-1:0];
  assign home = cur.home[MW-1:0];
  assign step = cur.step[MW-1:0];
  assign is_ins  = cur.func == oaht_pkg::FUNC_INSERT;
  assign is_find = cur.func == oaht_pkg::FUNC_SEARCH || cur.func == oaht_pkg::FUNC_REMOVE;

  always_comb begin
    case (cur.mode)
      oaht_pkg::MODE_QUAD:   delta = sq_inc;
      oaht_pkg::MODE_DOUBLE: delta = step;
      default:               delta = MW'(1);
    endcase
    t1 = {1'b0, off} + {1'b0, delta};
    off_next = (t1 >= {1'b0, m}) ? MW'(t1 - {1'b0, m}) : MW'(t1);
    t2 = {1'b0, sq_inc} + (MW+1)'(2);
    inc_next = (t2 >= {1'b0, m}) ? MW'(t2 - {1'b0, m}) : MW'(t2);
    t3 = {1'b0, home} + {1'b0, off_next};
    h_next = (t3 >= {1'b0, m}) ? MW'(t3 - {1'b0, m}) : MW'(t3);
  end

  // walk is over once the next probe is back at the start or m slots were seen
  assign walk_end = (h_next[DEPTH_W-1:0] == start) || (k == m);

  assign job_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) mem_mark[clr[DEPTH_W-1:0]] <= oaht_pkg::MARK_FREE;
    if (state == S_READ) begin
      rd_key  <= mem_key[h];
      rd_mark <= mem_mark[h];
    end
    if (state == S_CHECK && is_ins) begin
      if (rd_mark != oaht_pkg::MARK_USED) begin
        mem_key[h]  <= cur.key;
        mem_val[h]  <= cur.value;
        mem_mark[h] <= oaht_pkg::MARK_USED;
      end else if (rd_key == cur.key) begin
        mem_val[h] <= cur.value;
      end
    end
    if (state == S_CHECK && cur.func == oaht_pkg::FUNC_REMOVE &&
        rd_mark == oaht_pkg::MARK_USED && rd_key == cur.key)
      mem_mark[h] <= oaht_pkg::MARK_GONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr     <= '0;
      entries <= '0;
      colls   <= '0;
      rsp.valid <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr <= clr + MW'(1);
          if (clr == MW'(DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (job_valid) begin
            cur    <= job;
            h      <= job.home[DEPTH_W-1:0];
            start  <= job.home[DEPTH_W-1:0];
            k      <= MW'(1);
            off    <= '0;
            sq_inc <= MW'(1);
            state  <= S_READ;
          end
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          h      <= h_next[DEPTH_W-1:0];
          off    <= off_next;
          sq_inc <= inc_next;
          k      <= k + MW'(1);
          if (is_ins) begin
            if (rd_mark != oaht_pkg::MARK_USED) begin
              rsp.payload.status <= oaht_pkg::ST_NEW;
              rsp.payload.slot_index <= 10'(h);
              if (entries < 11'(DEPTH)) entries <= entries + 11'd1;
              state <= S_OUT;
            end else begin
              if (colls != 32'hFFFF_FFFF) colls <= colls + 32'd1;
              if (rd_key == cur.key) begin
                rsp.payload.status <= oaht_pkg::ST_UPDATED;
                rsp.payload.slot_index <= 10'(h);
                state <= S_OUT;
              end else if (walk_end) begin
                rsp.payload.status <= oaht_pkg::ST_FULL;
                rsp.payload.slot_index <= '0;
                state <= S_OUT;
              end else begin
                state <= S_READ;
              end
            end
          end else if (is_find) begin
            if (rd_mark == oaht_pkg::MARK_FREE) begin
              rsp.payload.status <= oaht_pkg::ST_MISSING;
              rsp.payload.slot_index <= '0;
              state <= S_OUT;
            end else if (rd_mark == oaht_pkg::MARK_USED && rd_key == cur.key) begin
              rsp.payload.status <= oaht_pkg::ST_FOUND;
              rsp.payload.slot_index <= 10'(h);
              if (cur.func == oaht_pkg::FUNC_REMOVE && entries != 11'd0)
                entries <= entries - 11'd1;
              state <= S_OUT;
            end else if (walk_end) begin
              rsp.payload.status <= oaht_pkg::ST_MISSING;
              rsp.payload.slot_index <= '0;
              state <= S_OUT;
            end else begin
              state <= S_READ;
            end
          end else begin
            rsp.payload.status <= oaht_pkg::ST_MISSING;
            rsp.payload.slot_index <= '0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!rsp.valid) begin
            rsp.valid <= 1'b1;
            rsp.payload.entries_held    <= entries;
            rsp.payload.collisions_seen <= colls;
          end else if (rsp.ready) begin
            rsp.valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The h update in CHECK also runs on a stop; the slot was latched already.
  a_rsp_in_out: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> state == S_OUT) else $error("response outside out state");
  a_no_job_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !job_ready) else $error("ready during clear");
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK |-> k <= m) else $error("probe walk too long");
endmodule

@@ hw/rtl/open_addressing_hash_table.sv @@
// Open-addressing hash table with linear, quadratic or double-hash probing.
// After reset a clearing pass frees every slot; one request may be taken
// and held in the front end meanwhile, and configuration writes are taken
// always (write them only while no request is in flight). The front end
// runs two bit-serial modulo reductions of the 31-bit key (in MOD1 and
// MOD2) and hands the job over, then the back end reads and compares each
// probed slot and presents the result, with probes ranging from 1 to
// table_size clamped to 3..1024. A one-entry job register separates the
// two parts, so the next request can be taken while the back end is still
// walking.
module open_addressing_hash_table (
  input  logic        clk,
  input  logic        rst,
  oaht_req_if.sink    req,
  oaht_rsp_if.source  rsp,
  oaht_cfg_if.sink    cfg
);
  logic [oaht_pkg::SIZE_W-1:0] table_size;
  logic [1:0] probe_mode;
  logic job_valid, job_ready;
  oaht_pkg::job_t job;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= 11'd1021;
      probe_mode <= oaht_pkg::MODE_LINEAR;
    end else if (cfg.valid) begin
      case (cfg.index)
        oaht_pkg::REG_TABLE_SIZE: table_size <= cfg.data;
        oaht_pkg::REG_PROBE_MODE: probe_mode <= cfg.data[1:0];
        default: ;
      endcase
    end
  end

  oaht_front u_front (
    .clk, .rst, .req, .table_size, .probe_mode,
    .job_valid, .job_ready, .job
  );

  oaht_back u_back (
    .clk, .rst, .job_valid, .job_ready, .job, .rsp
  );
endmodule
